[sv/rmmwf_pkg.sv]
// ----------------------------------------------------------------------------
// rmmwf_pkg
// Shared constants, types and channel-wise min/max helpers for the RGB
// square-window min/max filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmmwf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 5;
  localparam int LINES      = 2 * MAX_RADIUS;
  localparam int TAPS       = LINES + 1;

  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W  = NUM_CH * CH_W;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = 12;
  localparam int SLOT_W = $clog2(LINES);

  localparam int WID_W = 12;
  localparam int HGT_W = 13;
  localparam int RAD_W = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);
  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_MODE   = 2'd3
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [TAPS-1:0][PIX_W-1:0] tap_vec_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic             take_max;
  } win_cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] ccol;
    logic [ROW_W-1:0] crow;
    logic             last;
    logic             emit;
  } item_info_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    item_info_t        info;
  } col_req_t;

  typedef struct packed {
    pix_t       vert;
    item_info_t info;
  } col_item_t;

  // neutral element of the reduction
  function automatic pix_t ident_px(input logic take_max);
    return take_max ? '0 : '1;
  endfunction

  function automatic pix_t merge_px(input pix_t a, input pix_t b, input logic take_max);
    pix_t r;
    r = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if ((a[c*CH_W +: CH_W] > b[c*CH_W +: CH_W]) == take_max) begin
        r[c*CH_W +: CH_W] = a[c*CH_W +: CH_W];
      end else begin
        r[c*CH_W +: CH_W] = b[c*CH_W +: CH_W];
      end
    end
    return r;
  endfunction

  // balanced tree, ceil(log2(TAPS)) compare levels
  function automatic pix_t reduce_taps(input tap_vec_t v, input logic take_max);
    tap_vec_t t;
    t = v;
    for (int s = 1; s < TAPS; s = s * 2) begin
      for (int i = 0; i + s < TAPS; i = i + 2 * s) begin
        t[i] = merge_px(t[i], t[i + s], take_max);
      end
    end
    return t[0];
  endfunction

endpackage

`default_nettype wire

[sv/rmmwf_pos.sv]
// ----------------------------------------------------------------------------
// rmmwf_pos
// Configuration registers and raster position tracking; works out the line
// store slot, centre coordinates and result flags for each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmwf_pos (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [rmmwf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rmmwf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                                accept,
  input  wire logic                                frame_start,
  output rmmwf_pkg::col_req_t                      req,
  output rmmwf_pkg::win_cfg_t                      win_cfg
);

  localparam int WID_W  = rmmwf_pkg::WID_W;
  localparam int HGT_W  = rmmwf_pkg::HGT_W;
  localparam int RAD_W  = rmmwf_pkg::RAD_W;
  localparam int COL_W  = rmmwf_pkg::COL_W;
  localparam int ROW_W  = rmmwf_pkg::ROW_W;
  localparam int SLOT_W = rmmwf_pkg::SLOT_W;

  logic [WID_W-1:0]  width_r;
  logic [HGT_W-1:0]  height_r;
  logic [RAD_W-1:0]  radius_r;
  logic              mode_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [WID_W-1:0]  w_eff;
  logic [HGT_W-1:0]  h_eff;
  logic [RAD_W-1:0]  rad_eff;
  logic [RAD_W:0]    two_r;

  logic [WID_W-1:0]  c0, cn;
  logic [HGT_W-1:0]  r0, rn;
  logic [SLOT_W-1:0] s0, sn;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(rmmwf_pkg::LINES - 1)) ? '0 : s + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rmmwf_pkg::WIDTH_RST;
      height_r <= rmmwf_pkg::HEIGHT_RST;
      radius_r <= rmmwf_pkg::RADIUS_RST;
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (rmmwf_pkg::cfg_reg_t'(cfg_index))
        rmmwf_pkg::REG_WIDTH:  width_r  <= cfg_wdata[WID_W-1:0];
        rmmwf_pkg::REG_HEIGHT: height_r <= cfg_wdata[HGT_W-1:0];
        rmmwf_pkg::REG_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
        rmmwf_pkg::REG_MODE:   mode_r   <= cfg_wdata[0];
      endcase
    end
  end

  // saturate the register values to the supported range
  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(rmmwf_pkg::MAX_WIDTH)) begin
      w_eff = WID_W'(rmmwf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HGT_W'(1);
    end else if (height_r > HGT_W'(rmmwf_pkg::MAX_HEIGHT)) begin
      h_eff = HGT_W'(rmmwf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    rad_eff = (radius_r > RAD_W'(rmmwf_pkg::MAX_RADIUS)) ?
              RAD_W'(rmmwf_pkg::MAX_RADIUS) : radius_r;
    two_r = {rad_eff, 1'b0};
  end

  always_comb begin
    c0 = frame_start ? '0 : WID_W'(col_r);
    r0 = frame_start ? '0 : HGT_W'(row_r);
    s0 = frame_start ? '0 : slot_r;
    // stale position after a size change
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + 1'b1;
      s0 = slot_inc(s0);
    end
    if (r0 >= h_eff) begin
      r0 = '0;
      s0 = '0;
    end

    cn = c0 + 1'b1;
    rn = r0;
    sn = s0;
    if (cn >= w_eff) begin
      cn = '0;
      rn = r0 + 1'b1;
      sn = slot_inc(s0);
      if (rn >= h_eff) begin
        rn = '0;
        sn = '0;
      end
    end
    col_nxt  = COL_W'(cn);
    row_nxt  = ROW_W'(rn);
    slot_nxt = sn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_comb begin
    req.col       = COL_W'(c0);
    req.slot      = s0;
    req.info.ccol = COL_W'(c0 - WID_W'(rad_eff));
    req.info.crow = ROW_W'(r0 - HGT_W'(rad_eff));
    req.info.last = (c0 + 1'b1 == w_eff) && (r0 + 1'b1 == h_eff);
    req.info.emit = (c0 >= WID_W'(two_r)) && (r0 >= HGT_W'(two_r));
    win_cfg.rad      = rad_eff;
    win_cfg.take_max = mode_r;
  end

endmodule

`default_nettype wire

[sv/rmmwf_col_store.sv]
// ----------------------------------------------------------------------------
// rmmwf_col_store
// Line store memory, one word per column holding all buffered lines, and
// the vertical min/max over the window rows of the current column.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmwf_col_store (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire rmmwf_pkg::pix_t        px,
  input  wire rmmwf_pkg::col_req_t    req,
  input  wire rmmwf_pkg::win_cfg_t    win_cfg,
  input  wire logic                   s2_free,
  output logic                        s1_free,
  output logic                        s1_valid,
  output rmmwf_pkg::col_item_t        s1_item
);

  localparam int LINES  = rmmwf_pkg::LINES;
  localparam int TAPS   = rmmwf_pkg::TAPS;
  localparam int PIX_W  = rmmwf_pkg::PIX_W;
  localparam int SLOT_W = rmmwf_pkg::SLOT_W;
  localparam int LAG_W  = SLOT_W + 1;

  logic [LINES-1:0][PIX_W-1:0] line_mem_r [rmmwf_pkg::MAX_WIDTH];
  logic [LINES-1:0][PIX_W-1:0] rd_r;

  logic                   s1_v_r, s1_v_nxt;
  rmmwf_pkg::pix_t        px_r;
  logic [SLOT_W-1:0]      slot_r;
  rmmwf_pkg::item_info_t  info_r;

  logic [LAG_W-1:0]       row_lag;
  rmmwf_pkg::tap_vec_t    vert_in;

  // old lanes are read, the current line's lane is overwritten in place
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem_r[req.col];
      line_mem_r[req.col][req.slot] <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r   <= px;
      slot_r <= req.slot;
      info_r <= req.info;
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s2_free) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // lane j holds the line that is row_lag rows above the current one
  always_comb begin
    row_lag = '0;
    vert_in = '0;
    for (int j = 0; j < LINES; j++) begin
      if (slot_r > SLOT_W'(j)) begin
        row_lag = LAG_W'(slot_r) - LAG_W'(j);
      end else begin
        row_lag = LAG_W'(slot_r) + LAG_W'(LINES) - LAG_W'(j);
      end
      vert_in[j] = (row_lag <= LAG_W'({win_cfg.rad, 1'b0})) ?
                   rd_r[j] : rmmwf_pkg::ident_px(win_cfg.take_max);
    end
    vert_in[TAPS-1] = px_r;
  end

  assign s1_item.vert = rmmwf_pkg::reduce_taps(vert_in, win_cfg.take_max);
  assign s1_item.info = info_r;
  assign s1_valid     = s1_v_r;
  assign s1_free      = !s1_v_r || s2_free;

endmodule

`default_nettype wire

[sv/rmmwf_row_window.sv]
// ----------------------------------------------------------------------------
// rmmwf_row_window
// Shift line of column extremes, horizontal min/max over the window and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmwf_row_window (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   s1_valid,
  input  wire rmmwf_pkg::col_item_t   s1_item,
  input  wire rmmwf_pkg::win_cfg_t    win_cfg,
  output logic                        s2_free,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output rmmwf_pkg::pix_t             out_pix,
  output rmmwf_pkg::item_info_t       out_info
);

  localparam int TAPS  = rmmwf_pkg::TAPS;
  localparam int TAP_W = $clog2(TAPS) + 1;

  rmmwf_pkg::tap_vec_t    taps_r;
  rmmwf_pkg::item_info_t  info2_r;
  logic                   s2_v_r, s2_v_nxt;
  logic                   out_v_r, out_v_nxt;
  rmmwf_pkg::pix_t        out_pix_r;
  rmmwf_pkg::item_info_t  out_info_r;

  logic                   s2_go, s2_load, out_load;
  rmmwf_pkg::tap_vec_t    horiz_in;
  rmmwf_pkg::pix_t        horiz;

  // items without a result still pass to keep the taps in step
  assign s2_go    = s2_v_r && (!info2_r.emit || !out_v_r || out_ready);
  assign s2_free  = !s2_v_r || s2_go;
  assign s2_load  = s1_valid && s2_free;
  assign out_load = s2_go && info2_r.emit;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      taps_r  <= {taps_r[TAPS-2:0], s1_item.vert};
      info2_r <= s1_item.info;
    end
  end

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      horiz_in[k] = (TAP_W'(k) <= TAP_W'({win_cfg.rad, 1'b0})) ?
                    taps_r[k] : rmmwf_pkg::ident_px(win_cfg.take_max);
    end
    horiz = rmmwf_pkg::reduce_taps(horiz_in, win_cfg.take_max);
  end

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (s2_load) begin
      s2_v_nxt = 1'b1;
    end else if (s2_go) begin
      s2_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r  <= horiz;
      out_info_r <= info2_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_pix   = out_pix_r;
  assign out_info  = out_info_r;

endmodule

`default_nettype wire

[sv/rgb_min_max_window_filter_top.sv]
// ----------------------------------------------------------------------------
// rgb_min_max_window_filter_top
// RGB square-window minimum / maximum (erosion / dilation) filter.
//
// Pixels enter in raster order on the in_ stream, one item per clock while in_tready
// is high; in_tuser marks the first pixel of a frame and restarts the position
// counters. For every centre whose window of side 2*radius+1 lies inside the
// image, one result leaves on the out_ stream with the channel min or max
// and the centre position; out_tlast flags the result of the frame's last
// pixel. Border centres produce nothing.
// Each result is registered in the column stage, the tap stage and the output
// register. Throughput is one item per clock unless out_tready stalls, set by
// the single line-store access per item (one 2048 x 240 bit word read and one
// lane written per column) followed by two reduction stages.
// Reset clears counters and pipeline valids and loads the registers with
// 640 x 480, radius 2, minimum. The line store is not cleared.
// When out_tready is low, interior stages fill their bubbles and then
// in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_min_max_window_filter_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // [7:0] in_red, [15:8] in_green, [23:16] in_blue
  input  wire logic [rmmwf_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [0] frame_start
  input  wire logic                                   in_tuser,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue,
  // [34:24] centre_column, [46:35] centre_row, [47] zero
  output logic [rmmwf_pkg::OUT_TDATA_W-1:0]           out_tdata,
  output logic                                        out_tlast,
  input  wire logic                                   cfg_we,
  input  wire logic [rmmwf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [rmmwf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int CH_W = rmmwf_pkg::CH_W;

  logic                   accept;
  rmmwf_pkg::pix_t        px;
  rmmwf_pkg::col_req_t    req;
  rmmwf_pkg::win_cfg_t    win_cfg;
  logic                   s1_free, s1_valid, s2_free;
  rmmwf_pkg::col_item_t   s1_item;
  rmmwf_pkg::pix_t        out_pix;
  rmmwf_pkg::item_info_t  out_info;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = s1_free;
  // internal pixel word keeps red in the top byte
  assign px = {in_tdata[CH_W-1:0], in_tdata[2*CH_W-1:CH_W], in_tdata[3*CH_W-1:2*CH_W]};

  rmmwf_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .frame_start (in_tuser),
    .req         (req),
    .win_cfg     (win_cfg)
  );

  rmmwf_col_store u_col_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .px       (px),
    .req      (req),
    .win_cfg  (win_cfg),
    .s2_free  (s2_free),
    .s1_free  (s1_free),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  rmmwf_row_window u_row_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .win_cfg   (win_cfg),
    .s2_free   (s2_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_info  (out_info)
  );

  assign out_tdata = {1'b0, out_info.crow, out_info.ccol,
                      out_pix[CH_W-1:0], out_pix[2*CH_W-1:CH_W], out_pix[3*CH_W-1:2*CH_W]};
  assign out_tlast = out_info.last;

  // an empty column stage always takes an item
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_tready)
    else $error("in_tready low with empty column stage");

  // every accepted item lands in the column stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid)
    else $error("accepted item missing from column stage");

  // a blocked column stage keeps its item
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !s2_free && !accept |=> s1_valid && $stable(s1_item.info))
    else $error("column stage item changed while blocked");

endmodule

`default_nettype wire
